>>> src/fifo_queue_with_remove_by_value_macros.svh
// Assertion macros used by the checker of the queue.
`ifndef FIFO_QUEUE_WITH_REMOVE_BY_VALUE_MACROS_SVH
`define FIFO_QUEUE_WITH_REMOVE_BY_VALUE_MACROS_SVH

// Condition and consequence in the same cycle.
`define FQRV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fifo queue check failed");

// Consequence in the cycle after the condition.
`define FQRV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fifo queue check failed");

`endif

>>> src/fqrv_pkg.sv
package fqrv_pkg;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int OCC_W    = 5;

    localparam logic [ACTION_W-1:0] ACT_ENQUEUE  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQUEUE  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CONTAINS = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd4;

    typedef struct packed {
        logic enq;
        logic deq;
        logic rem;
        logic clr;
    } t_cell_ctl;

endpackage

>>> src/fqrv_if.sv
interface fqrv_in_if;
    logic                             valid;
    logic                             ready;
    logic [fqrv_pkg::ACTION_W-1:0]    action;
    logic [fqrv_pkg::VALUE_W-1:0]     value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

interface fqrv_out_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic                             rejected;
    logic [fqrv_pkg::VALUE_W-1:0]     front_value;
    logic [fqrv_pkg::OCC_W-1:0]       occupancy;
    logic                             is_empty;

    modport source (output valid, output hit, output rejected, output front_value,
                    output occupancy, output is_empty, input ready);
    modport sink (input valid, input hit, input rejected, input front_value,
                  input occupancy, input is_empty, output ready);
endinterface

>>> src/fqrv_cell.sv
module fqrv_cell #(
    parameter int DATA_W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fqrv_pkg::t_cell_ctl i_ctl,
    input  logic [DATA_W-1:0]   i_key,
    input  logic                i_prev_valid,
    input  logic                i_next_valid,
    input  logic [DATA_W-1:0]   i_next_data,
    input  logic                i_found,
    output logic                o_valid,
    output logic [DATA_W-1:0]   o_data,
    output logic                o_found,
    output logic                o_n_valid,
    output logic [DATA_W-1:0]   o_n_data
);

    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    logic              n_valid;
    logic [DATA_W-1:0] n_data;
    logic              w_match;
    logic              w_shift;

    // A cell shifts toward the head on a dequeue, or on a remove once the
    // first match lies at or before it.
    assign w_match = r_valid && (r_data == i_key);
    assign o_found = i_found || w_match;
    assign w_shift = i_ctl.deq || (i_ctl.rem && o_found);

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctl.clr) begin
            n_valid = 1'b0;
        end else if (w_shift) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end else if (i_ctl.enq && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_data  = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid   = r_valid;
    assign o_data    = r_data;
    assign o_n_valid = n_valid;
    assign o_n_data  = n_data;

endmodule

>>> src/fifo_queue_with_remove_by_value.sv
// Results are registered on acceptance and presented in the next cycle.
// Throughput: one transaction per cycle while the sink takes results; the
// match chain rippling combinationally through the cells sets the clock period.
// Reset: synchronous, active low; empties the queue and drops any pending
// result. Stored values are not cleared.
module fifo_queue_with_remove_by_value #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ELEM_WIDTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fqrv_in_if.sink     i_in,
    fqrv_out_if.source  o_out
);

    localparam int STORE_W = (ELEM_WIDTH < fqrv_pkg::VALUE_W) ? ELEM_WIDTH
                                                               : fqrv_pkg::VALUE_W;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    logic                    r_hit;
    logic                    r_rejected;
    logic [fqrv_pkg::VALUE_W-1:0] r_front;
    logic [fqrv_pkg::OCC_W-1:0]   r_occ;
    logic                    r_empty;

    fqrv_pkg::t_cell_ctl     w_ctl;
    logic                    w_accept;
    logic                    w_full;
    logic                    w_hit;
    logic                    w_rejected;
    logic [STORE_W-1:0]      w_key;
    logic [fqrv_pkg::VALUE_W-1:0] w_count_ext;

    logic                    w_valid   [QUEUE_DEPTH];
    logic [STORE_W-1:0]      w_data    [QUEUE_DEPTH];
    logic                    w_n_valid [QUEUE_DEPTH];
    logic [STORE_W-1:0]      w_n_data  [QUEUE_DEPTH];
    logic                    w_found   [QUEUE_DEPTH+1];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_key      = i_in.value[STORE_W-1:0];
    assign w_full     = (r_count == CNT_W'(QUEUE_DEPTH));

    always_comb begin
        w_ctl = '0;
        if (w_accept) begin
            case (i_in.action)
                fqrv_pkg::ACT_ENQUEUE: w_ctl.enq = 1'b1;
                fqrv_pkg::ACT_DEQUEUE: w_ctl.deq = 1'b1;
                fqrv_pkg::ACT_REMOVE:  w_ctl.rem = 1'b1;
                fqrv_pkg::ACT_CLEAR:   w_ctl.clr = 1'b1;
                default:               w_ctl = '0;
            endcase
        end
    end

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic               w_prev_valid;
        logic               w_next_valid;
        logic [STORE_W-1:0] w_next_data;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_data  = '0;
        end else begin : g_inner
            assign w_next_valid = w_valid[g+1];
            assign w_next_data  = w_data[g+1];
        end

        fqrv_cell #(
            .DATA_W (STORE_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (w_key),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_data  (w_next_data),
            .i_found      (w_found[g]),
            .o_valid      (w_valid[g]),
            .o_data       (w_data[g]),
            .o_found      (w_found[g+1]),
            .o_n_valid    (w_n_valid[g]),
            .o_n_data     (w_n_data[g])
        );
    end

    assign w_hit = w_accept && w_found[QUEUE_DEPTH] &&
                   ((i_in.action == fqrv_pkg::ACT_REMOVE) ||
                    (i_in.action == fqrv_pkg::ACT_CONTAINS));
    assign w_rejected = w_ctl.enq && w_full;

    always_comb begin
        n_count = r_count;
        if (w_ctl.clr) begin
            n_count = '0;
        end else if (w_ctl.enq && !w_full) begin
            n_count = r_count + CNT_W'(1);
        end else if ((w_ctl.deq && (r_count != '0)) || (w_ctl.rem && w_hit)) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_count_ext = fqrv_pkg::VALUE_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit      <= w_hit;
            r_rejected <= w_rejected;
            r_front    <= w_n_valid[0] ? fqrv_pkg::VALUE_W'(w_n_data[0]) : '0;
            r_occ      <= w_count_ext[fqrv_pkg::OCC_W-1:0];
            r_empty    <= (n_count == '0);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.hit         = r_hit;
    assign o_out.rejected    = r_rejected;
    assign o_out.front_value = r_front;
    assign o_out.occupancy   = r_occ;
    assign o_out.is_empty    = r_empty;

endmodule

>>> src/fqrv_checker.sv
`include "fifo_queue_with_remove_by_value_macros.svh"

module fqrv_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_hit,
    input logic                          i_rejected,
    input logic [fqrv_pkg::VALUE_W-1:0]  i_front_value,
    input logic [fqrv_pkg::OCC_W-1:0]    i_occupancy,
    input logic                          i_is_empty
);

    // An empty queue shows a zero head.
    `FQRV_ASSERT_NOW(a_empty_front, i_clk, i_rst_n, i_out_valid && i_is_empty, i_front_value == '0)

    // A rejected enqueue comes only from a full queue: it never shows an empty queue or a match.
    `FQRV_ASSERT_NOW(a_reject_full, i_clk, i_rst_n, i_out_valid && i_rejected, !i_is_empty && !i_hit)

    // A result that waits for the sink holds its payload.
    `FQRV_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_hit) && $stable(i_rejected) && $stable(i_front_value) && $stable(i_occupancy) && $stable(i_is_empty))

endmodule

bind fifo_queue_with_remove_by_value fqrv_checker u_fqrv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_hit         (o_out.hit),
    .i_rejected    (o_out.rejected),
    .i_front_value (o_out.front_value),
    .i_occupancy   (o_out.occupancy),
    .i_is_empty    (o_out.is_empty)
);

>>> sim/fqrv_shadow_queue.sv
module fqrv_shadow_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fqrv_in_if   i_in_mon,
    fqrv_out_if  i_out_mon,
    output int   o_error_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                         hit;
        logic                         rejected;
        logic [fqrv_pkg::VALUE_W-1:0] front_value;
        logic [fqrv_pkg::OCC_W-1:0]   occupancy;
        logic                         is_empty;
    } t_queue_status;

    logic [fqrv_pkg::VALUE_W-1:0] shadow_vals[$];
    t_queue_status                outcomes_due[$];

    initial begin
        o_error_count = 0;
        o_pending     = 0;
    end

    function automatic t_queue_status apply_queue_action(
        logic [fqrv_pkg::ACTION_W-1:0] act,
        logic [fqrv_pkg::VALUE_W-1:0]  val);
        t_queue_status st;
        int            pos;
        int            i;
        st  = '0;
        pos = -1;
        case (act)
            fqrv_pkg::ACT_ENQUEUE: begin
                if (shadow_vals.size() >= QUEUE_DEPTH) begin
                    st.rejected = 1'b1;
                end else begin
                    shadow_vals.push_back(val);
                end
            end
            fqrv_pkg::ACT_DEQUEUE: begin
                if (shadow_vals.size() > 0) begin
                    void'(shadow_vals.pop_front());
                end
            end
            fqrv_pkg::ACT_REMOVE, fqrv_pkg::ACT_CONTAINS: begin
                for (i = 0; i < shadow_vals.size() && pos < 0; i++) begin
                    if (shadow_vals[i] == val) begin
                        pos = i;
                    end
                end
                if (pos >= 0) begin
                    st.hit = 1'b1;
                    if (act == fqrv_pkg::ACT_REMOVE) begin
                        shadow_vals.delete(pos);
                    end
                end
            end
            fqrv_pkg::ACT_CLEAR: begin
                shadow_vals.delete();
            end
            default: begin
            end
        endcase
        st.front_value = (shadow_vals.size() > 0) ? shadow_vals[0] : '0;
        st.occupancy   = fqrv_pkg::OCC_W'(shadow_vals.size());
        st.is_empty    = (shadow_vals.size() == 0);
        return st;
    endfunction

    function automatic void note_error(string what, t_queue_status want, t_queue_status got);
        if (o_error_count < MAX_REPORTS) begin
            $display("%0t %s: want hit=%0b rej=%0b front=%h occ=%0d empty=%0b", $realtime,
                     what, want.hit, want.rejected, want.front_value, want.occupancy,
                     want.is_empty);
            $display("%0t %s: got  hit=%0b rej=%0b front=%h occ=%0d empty=%0b", $realtime,
                     what, got.hit, got.rejected, got.front_value, got.occupancy,
                     got.is_empty);
        end
        o_error_count++;
    endfunction

    always @(posedge i_clk) begin
        t_queue_status got;
        t_queue_status want;
        if (i_rst_n) begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = {i_out_mon.hit, i_out_mon.rejected, i_out_mon.front_value,
                       i_out_mon.occupancy, i_out_mon.is_empty};
                if (outcomes_due.size() == 0) begin
                    note_error("result with no transaction waiting", '0, got);
                end else begin
                    want = outcomes_due.pop_front();
                    if (got.hit !== want.hit || got.rejected !== want.rejected ||
                        got.front_value !== want.front_value ||
                        got.occupancy !== want.occupancy || got.is_empty !== want.is_empty) begin
                        note_error("result mismatch", want, got);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                outcomes_due.push_back(apply_queue_action(i_in_mon.action, i_in_mon.value));
            end
            o_pending = outcomes_due.size();
        end
    end

endmodule

>>> sim/tb_fifo_queue_with_remove_by_value.sv
module tb_fifo_queue_with_remove_by_value;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH  = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RX_HOLD_LEN  = 60;
    localparam int PHASE_ITEMS  = 185;

    localparam logic [fqrv_pkg::ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [fqrv_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [fqrv_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    int          error_count;
    int          pending;
    int unsigned cycle_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          rx_hold_req;
    logic [fqrv_pkg::VALUE_W-1:0] common_vals[6];

    fqrv_in_if  in_ch ();
    fqrv_out_if out_ch ();

    fifo_queue_with_remove_by_value #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ELEM_WIDTH  (fqrv_pkg::VALUE_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    fqrv_shadow_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) shadow_u (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The receiver stalls at random, or for one long stretch when asked.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (RX_HOLD_LEN) @(posedge i_clk);
            end
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(logic [fqrv_pkg::ACTION_W-1:0] act,
                             logic [fqrv_pkg::VALUE_W-1:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.value  <= val;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        @(posedge i_clk);
    endtask

    function automatic logic [fqrv_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(99) < 70) begin
            return common_vals[$urandom_range(5)];
        end
        return $urandom;
    endfunction

    function automatic logic [fqrv_pkg::ACTION_W-1:0] pick_action();
        int r;
        r = $urandom_range(99);
        if (r < 42) begin
            return fqrv_pkg::ACT_ENQUEUE;
        end else if (r < 57) begin
            return fqrv_pkg::ACT_DEQUEUE;
        end else if (r < 75) begin
            return fqrv_pkg::ACT_REMOVE;
        end else if (r < 92) begin
            return fqrv_pkg::ACT_CONTAINS;
        end else if (r < 96) begin
            return fqrv_pkg::ACT_CLEAR;
        end else if (r < 97) begin
            return ACT_SPARE_5;
        end else if (r < 98) begin
            return ACT_SPARE_6;
        end
        return ACT_SPARE_7;
    endfunction

    task automatic run_random(int count, int tx_pct, int rx_pct, int hold_at);
        int n;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (n = 0; n < count; n++) begin
            if (n == hold_at) begin
                rx_hold_req = 1'b1;
            end
            send_item(pick_action(), pick_value());
        end
    endtask

    initial begin
        int i;
        logic [fqrv_pkg::VALUE_W-1:0] fill_val;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.action = fqrv_pkg::ACT_ENQUEUE;
        in_ch.value  = '0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_req  = 1'b0;
        common_vals[0] = '0;
        common_vals[1] = '1;
        for (i = 2; i < 6; i++) begin
            common_vals[i] = $urandom;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Operations on an empty queue, including two of the unused action codes.
        send_item(fqrv_pkg::ACT_DEQUEUE, 32'h0000_0005);
        send_item(fqrv_pkg::ACT_REMOVE, 32'h0000_0005);
        send_item(fqrv_pkg::ACT_CONTAINS, 32'h0000_0005);
        send_item(ACT_SPARE_5, '1);
        send_item(ACT_SPARE_6, '1);

        // Fill to capacity with the extreme values and a duplicate.
        for (i = 0; i < QUEUE_DEPTH; i++) begin
            case (i)
                0:       fill_val = '0;
                1:       fill_val = '1;
                2, 9:    fill_val = 32'h5A5A_5A5A;
                15:      fill_val = 32'hA5A5_0F0F;
                default: fill_val = $urandom;
            endcase
            send_item(fqrv_pkg::ACT_ENQUEUE, fill_val);
        end
        send_item(fqrv_pkg::ACT_ENQUEUE, 32'h1234_5678);
        send_item(ACT_SPARE_7, '0);
        send_item(fqrv_pkg::ACT_CONTAINS, 32'hA5A5_0F0F);
        send_item(fqrv_pkg::ACT_REMOVE, 32'hA5A5_0F0F);
        send_item(fqrv_pkg::ACT_REMOVE, 32'h5A5A_5A5A);
        send_item(fqrv_pkg::ACT_REMOVE, 32'h1234_5678);
        send_item(fqrv_pkg::ACT_DEQUEUE, '0);
        send_item(fqrv_pkg::ACT_CLEAR, '0);
        wait_drained();

        run_random(PHASE_ITEMS, 37, 49, -1);
        wait_drained();
        run_random(PHASE_ITEMS, 49, 37, -1);
        run_random(PHASE_ITEMS, 0, 0, 40);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (error_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
